[src/depth_pixel_pick_nearest_valid_assert.svh]
// Assertion macros for the nearest-valid depth picker.
// Used by the port checker; depends on nothing else.
`ifndef DEPTH_PIXEL_PICK_NEAREST_VALID_ASSERT_SVH
`define DEPTH_PIXEL_PICK_NEAREST_VALID_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define DPNV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define DPNV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dpnv_pkg.sv]
// Shared types and constants for the nearest-valid depth picker.
// No dependencies; every other source file but the assertion header imports this package.
package dpnv_pkg;

  // Sizing
  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 8;
  localparam int SIZE_W      = COORD_BITS + 1;
  localparam int CFG_COORD_W = 12;
  localparam int CFG_SIZE_W  = 13;
  localparam int CFG_RAD_W   = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int SAMPLE_W    = 16;
  localparam int SCALE_W     = 16;
  localparam int MICRO_W     = 32;
  localparam int WIDE_W      = (SIZE_W > CFG_SIZE_W) ? SIZE_W : CFG_SIZE_W;
  localparam int DIST_W      = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int D2_W        = 2 * RADIUS_BITS + 1;
  localparam int ROOT_W      = RADIUS_BITS + 2;
  localparam int SQ_W        = 2 * ROOT_W;
  localparam int RING_W      = RADIUS_BITS + 1;
  localparam int BIT_W       = $clog2(ROOT_W);

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TARGET_COL   = 3'd0,
    CFG_TARGET_ROW   = 3'd1,
    CFG_USE_CENTRE   = 3'd2,
    CFG_SEARCH_ON    = 3'd3,
    CFG_RADIUS_LIMIT = 3'd4,
    CFG_FRAME_COLS   = 3'd5,
    CFG_FRAME_ROWS   = 3'd6,
    CFG_SCALE_MICRO  = 3'd7
  } cfg_idx_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_TARGET  = 2'd0,
    ST_SEARCH  = 2'd1,
    ST_INVALID = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] depth_sample;
    logic                frame_end;
  } in_word_t;

  typedef struct packed {
    status_t                status;
    logic [SAMPLE_W-1:0]    raw_depth;
    logic [MICRO_W-1:0]     depth_micro;
    logic [CFG_COORD_W-1:0] pick_col;
    logic [CFG_COORD_W-1:0] pick_row;
  } out_word_t;

  // Decoded view of the configuration
  typedef struct packed {
    logic [SIZE_W-1:0]      cols;
    logic [SIZE_W-1:0]      rows;
    logic [COORD_BITS-1:0]  tc;
    logic [COORD_BITS-1:0]  tr;
    logic                   in_range;
    logic                   search_en;
    logic [RADIUS_BITS-1:0] radius;
    logic [SCALE_W-1:0]     scale;
  } cfg_view_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;
    logic             eval;
    logic             square;
    logic             root_step;
    logic             fix;
    logic             update;
    logic             result;
    logic [BIT_W-1:0] bit_idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cand;
    logic last;
    logic out_free;
  } sts_t;

  function automatic logic depth_ok(input logic [SAMPLE_W-1:0] v);
    return (v != '0) && (v != '1);
  endfunction

endpackage

[src/dpnv_cfg.sv]
// Configuration registers and decoded frame geometry and target point.
// Depends on dpnv_pkg.
module dpnv_cfg import dpnv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_view_t             view
);

  logic [CFG_COORD_W-1:0] target_col_r, target_row_r;
  logic                   use_centre_r, search_on_r;
  logic [CFG_RAD_W-1:0]   radius_r;
  logic [CFG_SIZE_W-1:0]  frame_cols_r, frame_rows_r;
  logic [SCALE_W-1:0]     scale_r;

  logic [WIDE_W-1:0] cols_w, rows_w;
  logic [SIZE_W-1:0] cols, rows;
  logic [COORD_BITS-1:0] tc, tr;

  localparam logic [WIDE_W-1:0] FRAME_MAX = WIDE_W'(1) << COORD_BITS;

  // Write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_col_r <= CFG_COORD_W'(350);
      target_row_r <= CFG_COORD_W'(175);
      use_centre_r <= 1'b0;
      search_on_r  <= 1'b1;
      radius_r     <= CFG_RAD_W'(50);
      frame_cols_r <= CFG_SIZE_W'(640);
      frame_rows_r <= CFG_SIZE_W'(480);
      scale_r      <= SCALE_W'(250);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_TARGET_COL:   target_col_r <= CFG_COORD_W'(cfg_wdata);
        CFG_TARGET_ROW:   target_row_r <= CFG_COORD_W'(cfg_wdata);
        CFG_USE_CENTRE:   use_centre_r <= cfg_wdata[0];
        CFG_SEARCH_ON:    search_on_r  <= cfg_wdata[0];
        CFG_RADIUS_LIMIT: radius_r     <= CFG_RAD_W'(cfg_wdata);
        CFG_FRAME_COLS:   frame_cols_r <= CFG_SIZE_W'(cfg_wdata);
        CFG_FRAME_ROWS:   frame_rows_r <= CFG_SIZE_W'(cfg_wdata);
        CFG_SCALE_MICRO:  scale_r      <= SCALE_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Clamp frame size: zero acts as one, oversize acts as the coordinate span
  always_comb begin
    cols_w = WIDE_W'(frame_cols_r);
    rows_w = WIDE_W'(frame_rows_r);
    if (cols_w == '0) cols_w = WIDE_W'(1);
    else if (cols_w > FRAME_MAX) cols_w = FRAME_MAX;
    if (rows_w == '0) rows_w = WIDE_W'(1);
    else if (rows_w > FRAME_MAX) rows_w = FRAME_MAX;
    cols = SIZE_W'(cols_w);
    rows = SIZE_W'(rows_w);
  end

  // Pick target point
  always_comb begin
    if (use_centre_r) begin
      tc = COORD_BITS'(cols >> 1);
      tr = COORD_BITS'(rows >> 1);
    end else begin
      tc = COORD_BITS'(target_col_r);
      tr = COORD_BITS'(target_row_r);
    end
  end

  assign view.cols      = cols;
  assign view.rows      = rows;
  assign view.tc        = tc;
  assign view.tr        = tr;
  assign view.in_range  = (SIZE_W'(tc) < cols) && (SIZE_W'(tr) < rows);
  assign view.radius    = RADIUS_BITS'(radius_r);
  assign view.search_en = search_on_r && (RADIUS_BITS'(radius_r) != '0);
  assign view.scale     = scale_r;

endmodule

[src/dpnv_ctrl.sv]
// Sequencer for one pixel word: evaluate, ring search for candidates, then the result on frame end.
// Depends on dpnv_pkg.
module dpnv_ctrl import dpnv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SQUARE,
    S_ROOT,
    S_FIX,
    S_UPDATE,
    S_RESULT
  } state_t;

  state_t           state_r, state_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_EVAL;
      S_EVAL: begin
        if (sts.cand) state_nxt = S_SQUARE;
        else if (sts.last) state_nxt = S_RESULT;
        else state_nxt = S_IDLE;
      end
      S_SQUARE: begin
        state_nxt = S_ROOT;
        bit_nxt   = BIT_W'(ROOT_W - 1);
      end
      S_ROOT: begin
        if (bit_r == '0) state_nxt = S_FIX;
        else bit_nxt = bit_r - BIT_W'(1);
      end
      S_FIX:    state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = sts.last ? S_RESULT : S_IDLE;
      S_RESULT: if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Hold state and bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

  // Issue commands
  assign in_ready      = (state_r == S_IDLE);
  assign cmd.load      = (state_r == S_IDLE) && in_valid;
  assign cmd.eval      = (state_r == S_EVAL);
  assign cmd.square    = (state_r == S_SQUARE);
  assign cmd.root_step = (state_r == S_ROOT);
  assign cmd.fix       = (state_r == S_FIX);
  assign cmd.update    = (state_r == S_UPDATE);
  assign cmd.result    = (state_r == S_RESULT) && sts.out_free;
  assign cmd.bit_idx   = bit_r;

endmodule

[src/dpnv_dp.sv]
// Datapath: raster counters, target capture, ring root unit, best tracker,
// result build and output register. Depends on dpnv_pkg.
module dpnv_dp import dpnv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  cfg_view_t cfg,
  input  in_word_t  in_data,
  output sts_t      sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // Current word
  logic [SAMPLE_W-1:0]    samp_r;
  logic                   last_r;
  // Frame state
  logic [COORD_BITS-1:0]  col_cnt_r, row_cnt_r;
  logic                   past_end_r;
  logic [SAMPLE_W-1:0]    target_val_r;
  logic [SAMPLE_W-1:0]    best_val_r;
  logic [COORD_BITS-1:0]  best_col_r, best_row_r;
  logic [RING_W-1:0]      best_ring_r;
  logic                   best_found_r;
  // Ring search
  logic [COORD_BITS-1:0]  cur_col_r, cur_row_r;
  logic [RADIUS_BITS-1:0] ax_r, ay_r;
  logic [D2_W-1:0]        d2_r;
  logic [ROOT_W-1:0]      root_r;
  logic [ROOT_W-1:0]      ring_r;
  // Output register
  logic                   out_valid_r;
  out_word_t              out_r;

  logic                   active, is_tgt, inbox;
  logic [COORD_BITS-1:0]  ax, ay;
  logic                   col_wrap, row_wrap;
  logic [ROOT_W-1:0]      trial;
  logic [SQ_W-1:0]        trial_sq, root_sq;
  logic                   wins;
  status_t                res_st;
  logic [SAMPLE_W-1:0]    res_raw;
  logic [COORD_BITS-1:0]  res_col, res_row;
  logic [MICRO_W-1:0]     res_micro;

  // Locate the current pixel against the target
  always_comb begin
    active = !past_end_r && (SIZE_W'(col_cnt_r) < cfg.cols) &&
             (SIZE_W'(row_cnt_r) < cfg.rows);
    ax = (col_cnt_r >= cfg.tc) ? col_cnt_r - cfg.tc : cfg.tc - col_cnt_r;
    ay = (row_cnt_r >= cfg.tr) ? row_cnt_r - cfg.tr : cfg.tr - row_cnt_r;
    is_tgt = (ax == '0) && (ay == '0);
    inbox  = (DIST_W'(ax) <= DIST_W'(cfg.radius)) &&
             (DIST_W'(ay) <= DIST_W'(cfg.radius)) && depth_ok(samp_r);
    col_wrap = (SIZE_W'(col_cnt_r) + SIZE_W'(1)) >= cfg.cols;
    row_wrap = (SIZE_W'(row_cnt_r) + SIZE_W'(1)) >= cfg.rows;
  end

  // Root unit: one bit per step, then round up
  always_comb begin
    trial    = root_r | (ROOT_W'(1) << cmd.bit_idx);
    trial_sq = SQ_W'(trial) * SQ_W'(trial);
    root_sq  = SQ_W'(root_r) * SQ_W'(root_r);
    wins     = (ring_r <= ROOT_W'(cfg.radius)) &&
               (!best_found_r || (ring_r < ROOT_W'(best_ring_r)));
  end

  // Build the frame result
  always_comb begin
    res_raw = '0;
    res_col = cfg.tc;
    res_row = cfg.tr;
    if (!cfg.in_range) begin
      res_st = ST_RANGE;
    end else if (depth_ok(target_val_r)) begin
      res_st  = ST_TARGET;
      res_raw = target_val_r;
    end else if (cfg.search_en && best_found_r) begin
      res_st  = ST_SEARCH;
      res_raw = best_val_r;
      res_col = best_col_r;
      res_row = best_row_r;
    end else begin
      res_st  = ST_INVALID;
      res_raw = target_val_r;
    end
    // Product of two 16-bit values never exceeds 32 bits
    if (res_st == ST_TARGET || res_st == ST_SEARCH)
      res_micro = MICRO_W'(res_raw) * MICRO_W'(cfg.scale);
    else
      res_micro = '0;
  end

  // Control state: counters, flags, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      past_end_r   <= 1'b0;
      target_val_r <= '0;
      best_found_r <= 1'b0;
      best_ring_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.eval && active) begin
        if (is_tgt) target_val_r <= samp_r;
        if (col_wrap) begin
          col_cnt_r <= '0;
          if (row_wrap) past_end_r <= 1'b1;
          else row_cnt_r <= row_cnt_r + COORD_BITS'(1);
        end else begin
          col_cnt_r <= col_cnt_r + COORD_BITS'(1);
        end
      end
      if (cmd.update && wins) begin
        best_found_r <= 1'b1;
        best_ring_r  <= RING_W'(ring_r);
      end
      if (cmd.result) begin
        // Clear frame state for the next frame
        col_cnt_r    <= '0;
        row_cnt_r    <= '0;
        past_end_r   <= 1'b0;
        target_val_r <= '0;
        best_found_r <= 1'b0;
        best_ring_r  <= '0;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_r <= in_data.depth_sample;
      last_r <= in_data.frame_end;
    end
    if (cmd.eval) begin
      cur_col_r <= col_cnt_r;
      cur_row_r <= row_cnt_r;
      ax_r      <= RADIUS_BITS'(ax);
      ay_r      <= RADIUS_BITS'(ay);
    end
    if (cmd.square) begin
      d2_r   <= D2_W'(ax_r) * D2_W'(ax_r) + D2_W'(ay_r) * D2_W'(ay_r);
      root_r <= '0;
    end
    if (cmd.root_step && (trial_sq <= SQ_W'(d2_r))) root_r <= trial;
    if (cmd.fix) ring_r <= (root_sq < SQ_W'(d2_r)) ? root_r + ROOT_W'(1) : root_r;
    if (cmd.update && wins) begin
      best_val_r <= samp_r;
      best_col_r <= cur_col_r;
      best_row_r <= cur_row_r;
    end
    if (cmd.result) begin
      out_r.status      <= res_st;
      out_r.raw_depth   <= res_raw;
      out_r.depth_micro <= res_micro;
      out_r.pick_col    <= CFG_COORD_W'(res_col);
      out_r.pick_row    <= CFG_COORD_W'(res_row);
    end
  end

  assign sts.cand     = active && !is_tgt && inbox;
  assign sts.last     = last_r;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

[src/depth_pixel_pick_nearest_valid.sv]
// Top level of the nearest-valid depth picker.
// Depends on dpnv_pkg, dpnv_cfg, dpnv_ctrl and dpnv_dp.
//
//   port group  direction  handshake            word
//   in_         input      in_valid/in_ready    in_word_t (pixel, frame end)
//   out_        output     out_valid/out_ready  out_word_t (one per frame)
//   cfg_        input      cfg_we               index cfg_addr, data cfg_wdata
//
// A pixel passes through evaluation; a valid pixel within the search box around the
// target then also goes through square, 10 root steps of the ring unit, round and compare.
// The frame-end word then builds and registers the result.
// The result register holds while out_ready is low; the next frame streams
// meanwhile and only its own result waits for the register to free up.
// Synchronous reset restores register defaults and clears the raster counters, target value and best flag.
module depth_pixel_pick_nearest_valid import dpnv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_view_t view;
  cmd_t      cmd;
  sts_t      sts;

  dpnv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .view      (view)
  );

  dpnv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpnv_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (view),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[src/dpnv_checker.sv]
// Port-level checks for the nearest-valid depth picker, bound to the top.
// Depends on dpnv_pkg and depth_pixel_pick_nearest_valid_assert.svh.
`include "depth_pixel_pick_nearest_valid_assert.svh"

module dpnv_checker import dpnv_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  logic stalled, in_take, ok_word, bad_word, range_word;

  // Classify the handshakes and the result word on the port
  assign stalled    = out_valid && !out_ready;
  assign in_take    = in_valid && in_ready;
  assign ok_word    = out_valid &&
                      (out_data.status == ST_TARGET || out_data.status == ST_SEARCH);
  assign bad_word   = out_valid &&
                      (out_data.status == ST_INVALID || out_data.status == ST_RANGE);
  assign range_word = out_valid && (out_data.status == ST_RANGE);

  // A pending result word stays until taken
  `DPNV_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(out_data), "not held")

  // Each pixel word is evaluated before the next one is taken
  `DPNV_ASSERT_NEXT(a_in_gap, clk, rst_n, in_take, !in_ready, "pixel words back to back")

  // Invalid and out-of-range results carry no depth
  `DPNV_ASSERT_NOW(a_no_micro, clk, rst_n, bad_word, out_data.depth_micro == '0, "stray depth")

  // A reported depth comes from a valid raw value
  `DPNV_ASSERT_NOW(a_raw_ok, clk, rst_n, ok_word, depth_ok(out_data.raw_depth), "bad raw")

  // Out-of-range results report zero raw depth
  `DPNV_ASSERT_NOW(a_range_raw, clk, rst_n, range_word, out_data.raw_depth == '0, "raw set")

endmodule

bind depth_pixel_pick_nearest_valid dpnv_checker u_dpnv_checker (.*);
